@@ rtl/core/wmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// wmsc_pkg: shared types and constants for the word-mixing stream cipher
// Opcodes, microcode actions, control word layout and the mixing constants.
// ----------------------------------------------------------------------------
package wmsc_pkg;

   localparam int WORD_W = 32;
   localparam int BYTE_W = 8;

   localparam logic [WORD_W-1:0] MIX_MUL   = 32'h8177_2013;
   localparam logic [WORD_W-1:0] MIX_ADD   = 32'h4912_2035;
   localparam logic [WORD_W-1:0] FOLD_INIT = 32'h8037_9251;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_START = 2'd0;
   localparam opcode_type OP_KEY   = 2'd1;
   localparam opcode_type OP_DATA  = 2'd2;
   localparam opcode_type OP_NONE  = 2'd3;

   // microcode actions
   typedef logic [2:0] act_type;
   localparam act_type ACT_IDLE      = 3'd0;
   localparam act_type ACT_CLEAR     = 3'd1;
   localparam act_type ACT_MIX       = 3'd2;
   localparam act_type ACT_ADDKEY    = 3'd3;
   localparam act_type ACT_EMIT_KS   = 3'd4;
   localparam act_type ACT_EMIT_ZERO = 3'd5;

   typedef logic [3:0] upc_type;
   localparam upc_type UPC_IDLE      = 4'd0;
   localparam upc_type UPC_CLEAR     = 4'd1;
   localparam upc_type UPC_START_MIX = 4'd2;
   localparam upc_type UPC_KEY_MIX0  = 4'd3;
   localparam upc_type UPC_KEY_ADD   = 4'd4;
   localparam upc_type UPC_KEY_MIX1  = 4'd5;
   localparam upc_type UPC_DATA_MIX  = 4'd6;
   localparam upc_type UPC_EMIT_KS   = 4'd7;
   localparam upc_type UPC_EMIT_ZERO = 4'd8;

   typedef struct packed {
      act_type act;
      upc_type next;
   } ucode_type;

   // datapath controls issued by the sequencer
   typedef struct packed {
      logic load_item;
      logic clear;
      logic mix;
      logic mix_last;
      logic add_key;
      logic emit;
      logic emit_ks;
   } ctl_type;

   function automatic ucode_type ucode_rom(input upc_type upc);
      ucode_type w;
      unique case (upc)
         UPC_IDLE:      w = '{act: ACT_IDLE,      next: UPC_IDLE};
         UPC_CLEAR:     w = '{act: ACT_CLEAR,     next: UPC_START_MIX};
         UPC_START_MIX: w = '{act: ACT_MIX,       next: UPC_EMIT_ZERO};
         UPC_KEY_MIX0:  w = '{act: ACT_MIX,       next: UPC_KEY_ADD};
         UPC_KEY_ADD:   w = '{act: ACT_ADDKEY,    next: UPC_KEY_MIX1};
         UPC_KEY_MIX1:  w = '{act: ACT_MIX,       next: UPC_EMIT_ZERO};
         UPC_DATA_MIX:  w = '{act: ACT_MIX,       next: UPC_EMIT_KS};
         UPC_EMIT_KS:   w = '{act: ACT_EMIT_KS,   next: UPC_IDLE};
         UPC_EMIT_ZERO: w = '{act: ACT_EMIT_ZERO, next: UPC_IDLE};
         default:       w = '{act: ACT_IDLE,      next: UPC_IDLE};
      endcase
      return w;
   endfunction

   function automatic upc_type entry_point(input opcode_type op);
      upc_type e;
      unique case (op)
         OP_START: e = UPC_CLEAR;
         OP_KEY:   e = UPC_KEY_MIX0;
         OP_DATA:  e = UPC_DATA_MIX;
         OP_NONE:  e = UPC_EMIT_ZERO;
         default:  e = UPC_EMIT_ZERO;
      endcase
      return e;
   endfunction

endpackage

@@ rtl/core/wmsc_seq.sv @@
// ----------------------------------------------------------------------------
// wmsc_seq: microcode sequencer
// Microprogram counter, word loop counter and control ROM decode.
// ----------------------------------------------------------------------------
module wmsc_seq #(
   parameter int STATE_WORDS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  wmsc_pkg::opcode_type opcode,
   input  logic                emit_ok,
   output logic                idle,
   output wmsc_pkg::ctl_type   ctl
);
   import wmsc_pkg::*;

   localparam int CNT_W = (STATE_WORDS > 2) ? $clog2(STATE_WORDS - 1) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STATE_WORDS - 2);

   upc_type          upc_ff, upc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   ucode_type        uword;
   logic             cnt_last;

   assign uword    = ucode_rom(upc_ff);
   assign cnt_last = (cnt_ff == CNT_LAST);
   assign idle     = (uword.act == ACT_IDLE);

   always_comb begin
      ctl    = '0;
      upc_in = upc_ff;
      cnt_in = cnt_ff;
      unique case (uword.act)
         ACT_IDLE: begin
            if (req_valid) begin
               ctl.load_item = 1'b1;
               upc_in        = entry_point(opcode);
            end
         end
         ACT_CLEAR: begin
            ctl.clear = 1'b1;
            upc_in    = uword.next;
         end
         ACT_MIX: begin
            // one word per cycle; stay on this step until the last word
            ctl.mix      = 1'b1;
            ctl.mix_last = cnt_last;
            if (cnt_last) begin
               cnt_in = '0;
               upc_in = uword.next;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ACT_ADDKEY: begin
            ctl.add_key = 1'b1;
            upc_in      = uword.next;
         end
         ACT_EMIT_KS, ACT_EMIT_ZERO: begin
            if (emit_ok) begin
               ctl.emit    = 1'b1;
               ctl.emit_ks = (uword.act == ACT_EMIT_KS);
               upc_in      = uword.next;
            end
         end
         default: begin
            upc_in = UPC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_IDLE;
         cnt_ff <= '0;
      end else begin
         upc_ff <= upc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/core/wmsc_dp.sv @@
// ----------------------------------------------------------------------------
// wmsc_dp: cipher datapath
// State word ring with one shared constant multiplier, key add and keystream.
// ----------------------------------------------------------------------------
module wmsc_dp #(
   parameter int STATE_WORDS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  wmsc_pkg::ctl_type                ctl,
   input  logic [7:0]                       key_char,
   input  logic [7:0]                       data_byte,
   output logic [7:0]                       out_byte
);
   import wmsc_pkg::*;

   // word 0 stays put; words 1..N-1 rotate so the word being mixed is in slot 1
   logic [WORD_W-1:0] w0_ff, w0_in;
   logic [WORD_W-1:0] ring_ff [STATE_WORDS-1:1];
   logic [WORD_W-1:0] ring_in [STATE_WORDS-1:1];
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [BYTE_W-1:0] key_ff, data_ff;
   logic [WORD_W-1:0] prod, nxt_word, new_word, fold;
   logic [WORD_W-1:0] key_ext;

   generate
      if (STATE_WORDS > 2) begin : g_next
         assign nxt_word = ctl.mix_last ? w0_ff : ring_ff[2];
      end else begin : g_next_w0
         assign nxt_word = w0_ff;
      end
   endgenerate

   assign prod     = ring_ff[1] * MIX_MUL;
   assign new_word = prod + MIX_ADD + nxt_word;
   assign key_ext  = {{(WORD_W-BYTE_W){key_ff[BYTE_W-1]}}, key_ff};

   always_comb begin
      fold = FOLD_INIT ^ w0_ff;
      for (int k = 1; k < STATE_WORDS; k++) begin
         fold = fold ^ ring_ff[k];
      end
      out_byte = fold[31:24] ^ fold[23:16] ^ fold[15:8] ^ fold[7:0] ^ data_ff;
   end

   always_comb begin
      w0_in  = w0_ff;
      acc_in = acc_ff;
      for (int k = 1; k < STATE_WORDS; k++) begin
         ring_in[k] = ring_ff[k];
      end
      priority if (ctl.clear) begin
         w0_in  = '0;
         acc_in = '0;
         for (int k = 1; k < STATE_WORDS; k++) begin
            ring_in[k] = '0;
         end
      end else if (ctl.mix) begin
         for (int k = 1; k < STATE_WORDS - 1; k++) begin
            ring_in[k] = ring_ff[k+1];
         end
         ring_in[STATE_WORDS-1] = new_word;
         if (ctl.mix_last) begin
            // fold the updated words into word 0 as the pass ends
            w0_in  = w0_ff ^ acc_ff ^ new_word;
            acc_in = '0;
         end else begin
            acc_in = acc_ff ^ new_word;
         end
      end else if (ctl.add_key) begin
         w0_in = w0_ff + key_ext;
      end else begin
         w0_in = w0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w0_ff  <= '0;
         acc_ff <= '0;
         for (int k = 1; k < STATE_WORDS; k++) begin
            ring_ff[k] <= '0;
         end
      end else begin
         w0_ff  <= w0_in;
         acc_ff <= acc_in;
         for (int k = 1; k < STATE_WORDS; k++) begin
            ring_ff[k] <= ring_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         key_ff  <= key_char;
         data_ff <= data_byte;
      end
   end

endmodule

@@ rtl/core/word_mixing_stream_cipher.sv @@
// ----------------------------------------------------------------------------
// word_mixing_stream_cipher: word-mixing keystream cipher, top level
// Item channel in, one result item out per accepted item, microcoded control.
// ----------------------------------------------------------------------------
// Steps per item: data runs one mix pass; start clears the words and runs one pass; key runs a
// pass, adds the key to word 0 and runs another; an unused opcode goes straight to the emit step.
// Each mix pass takes words 1..STATE_WORDS-1 one word a cycle through the single shared 32x32
// constant multiplier. The emit step waits while a held result is stalled, then raises rsp_tvalid.
// One item at a time: req_tready is high only while the sequencer idles, after the emit step.
// Synchronous reset clears the state words, idles the sequencer and drops rsp_tvalid.
module word_mixing_stream_cipher #(
   parameter int STATE_WORDS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // opcode[1:0], key_char[9:2], data_byte[17:10], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // out_byte[7:0]
);
   import wmsc_pkg::*;

   ctl_type    ctl;
   logic       idle;
   logic       emit_ok;
   logic [7:0] ks_byte;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_tdata_ff;

   assign emit_ok    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = idle;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   wmsc_seq #(.STATE_WORDS(STATE_WORDS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .opcode    (req_tdata[1:0]),
      .emit_ok   (emit_ok),
      .idle      (idle),
      .ctl       (ctl)
   );

   wmsc_dp #(.STATE_WORDS(STATE_WORDS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .key_char  (req_tdata[9:2]),
      .data_byte (req_tdata[17:10]),
      .out_byte  (ks_byte)
   );

   always_comb begin
      priority if (ctl.emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_tdata_ff <= ctl.emit_ks ? ks_byte : 8'h00;
      end
   end

endmodule

@@ rtl/core/wmsc_checker.sv @@
// ----------------------------------------------------------------------------
// wmsc_checker: port-level checks for the word-mixing stream cipher
// Watches the item handshakes of the top level over time.
// ----------------------------------------------------------------------------
module wmsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);
   import wmsc_pkg::*;

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // one item at a time: busy after every accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while previous item in work");

   // an unused opcode accepted with no result pending gives a zero result
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[1:0] == OP_NONE && !rsp_tvalid)
      |-> ##2 (rsp_tvalid && rsp_tdata == 8'h00))
      else $error("unused opcode did not give a zero result");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind word_mixing_stream_cipher wmsc_checker u_wmsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ bench/word_mixing_stream_cipher_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_mixing_stream_cipher_test: self-checking bench for the keystream cipher
// Streams start, key, data and unused-opcode items into the block with random
// gaps and output stalls. A local model of the eight mixing words predicts
// every out_byte. Results are checked in order against the predictions.
// ----------------------------------------------------------------------------
module word_mixing_stream_cipher_test;
   import wmsc_pkg::*;

   localparam int          CIPHER_WORDS = 8;
   localparam logic [31:0] WORD_MUL     = 32'h8177_2013;
   localparam logic [31:0] WORD_ADD     = 32'h4912_2035;
   localparam logic [31:0] FOLD_SEED    = 32'h8037_9251;
   localparam int          RANDOM_ITEMS = 1030;
   localparam int          STALL_LIMIT  = 4000;
   localparam int          MAX_SHOWN    = 30;

   typedef struct {
      opcode_type  op;
      logic [7:0]  key_char;
      logic [7:0]  data_byte;
      int unsigned gap;
      bit          drain;   // hold until every pending result is back
   } cipher_item_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // opcode[1:0], key_char[9:2], data_byte[17:10], zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // out_byte[7:0]

   cipher_item_type pending_items[$];
   logic [7:0]      expected_bytes[$];
   logic [31:0]     cipher_words[CIPHER_WORDS];

   int mismatch_count = 0;
   int bytes_checked  = 0;
   int op_seen[4]     = '{0, 0, 0, 0};
   int drain_waits    = 0;
   bit steady_source  = 0;
   bit steady_sink    = 0;

   word_mixing_stream_cipher #(.STATE_WORDS(CIPHER_WORDS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- predictor ----------------

   // words 1..N-1 in ascending order, each sees the old value of its successor;
   // the last one wraps to word 0, then all of them fold into word 0
   function void mix_pass();
      int nx;
      for (int i = 1; i < CIPHER_WORDS; i++) begin
         nx = (i + 1 < CIPHER_WORDS) ? i + 1 : 0;
         cipher_words[i] = cipher_words[i] * WORD_MUL + WORD_ADD + cipher_words[nx];
      end
      for (int i = 1; i < CIPHER_WORDS; i++)
         cipher_words[0] ^= cipher_words[i];
   endfunction

   function logic [7:0] keystream_byte();
      logic [31:0] folded;
      folded = FOLD_SEED;
      for (int i = 0; i < CIPHER_WORDS; i++)
         folded ^= cipher_words[i];
      return folded[31:24] ^ folded[23:16] ^ folded[15:8] ^ folded[7:0];
   endfunction

   function logic [7:0] predict_out_byte(input cipher_item_type it);
      logic [7:0] result;
      result = 8'h00;
      case (it.op)
         OP_START: begin
            foreach (cipher_words[i]) cipher_words[i] = '0;
            mix_pass();
         end
         OP_KEY: begin
            mix_pass();
            cipher_words[0] += {{24{it.key_char[7]}}, it.key_char};
            mix_pass();
         end
         OP_DATA: begin
            mix_pass();
            result = it.data_byte ^ keystream_byte();
         end
         default: ;   // unused opcode leaves the state alone
      endcase
      return result;
   endfunction

   task report_mismatch(input string msg);
      if (mismatch_count < MAX_SHOWN)
         $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // ---------------- stimulus ----------------

   task automatic queue_item(input opcode_type op, input logic [7:0] key_char,
                             input logic [7:0] data_byte, input bit drain);
      cipher_item_type it;
      it.op        = op;
      it.key_char  = key_char;
      it.data_byte = data_byte;
      it.gap       = steady_source ? 0 : $urandom_range(0, 17);
      it.drain     = drain;
      pending_items.push_back(it);
   endtask

   task automatic queue_random_item(input opcode_type op, input bit drain);
      queue_item(op, 8'($urandom), 8'($urandom), drain);
   endtask

   task build_stimulus();
      int          target;
      int          n;
      int          kind;
      bit          drain;
      // data before any start runs on the all-zero reset state
      queue_item(OP_DATA,  8'h00, 8'h00, 0);
      queue_item(OP_DATA,  8'hFF, 8'hFF, 0);
      queue_item(OP_NONE,  8'hFF, 8'hFF, 0);
      queue_item(OP_START, 8'hFF, 8'hFF, 1);
      queue_item(OP_KEY,   8'h80, 8'hFF, 0);   // most negative key byte
      queue_item(OP_KEY,   8'h7F, 8'h00, 0);
      queue_item(OP_KEY,   8'h00, 8'h55, 0);   // zero key still mixes twice
      queue_item(OP_KEY,   8'hFF, 8'hAA, 0);
      queue_item(OP_KEY,   8'h01, 8'h00, 0);
      queue_item(OP_DATA,  8'h00, 8'h00, 0);
      queue_item(OP_DATA,  8'hFF, 8'hFF, 0);
      queue_item(OP_DATA,  8'h55, 8'hAA, 0);
      queue_item(OP_DATA,  8'hAA, 8'h55, 0);
      queue_item(OP_NONE,  8'h00, 8'h00, 0);
      queue_item(OP_DATA,  8'h80, 8'h80, 0);
      queue_item(OP_DATA,  8'h01, 8'h01, 0);
      queue_item(OP_START, 8'h00, 8'h00, 1);
      queue_item(OP_KEY,   8'h00, 8'hFF, 0);
      queue_item(OP_DATA,  8'hFF, 8'h00, 0);
      queue_item(OP_START, 8'h80, 8'h7F, 0);   // restart right after data
      queue_item(OP_DATA,  8'h7F, 8'h80, 0);

      target = pending_items.size() + RANDOM_ITEMS;
      while (pending_items.size() < target) begin
         if ($urandom_range(0, 4) == 0) steady_source = ~steady_source;
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // noise: any opcode, any fields
            queue_random_item(opcode_type'($urandom_range(0, 3)), 0);
         end else if (kind == 1) begin
            // broken sequence: keys with no start, or start and keys, no data
            if ($urandom_range(0, 1)) queue_random_item(OP_START, 0);
            n = $urandom_range(1, 6);
            repeat (n) queue_random_item(OP_KEY, 0);
         end else begin
            drain = ($urandom_range(0, 7) == 0);
            queue_random_item(OP_START, drain);
            n = $urandom_range(1, 12);
            repeat (n) queue_random_item(OP_KEY, 0);
            n = $urandom_range(1, 30);
            repeat (n) begin
               if ($urandom_range(0, 29) == 0) queue_random_item(OP_NONE, 0);
               queue_random_item(OP_DATA, 0);
            end
         end
      end
   endtask

   // ---------------- driver ----------------

   cipher_item_type current_item;
   int unsigned     gap_count = 0;
   bit              drive_valid;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         gap_count   = 0;
         // block comes out of reset with every word at zero
         foreach (cipher_words[i]) cipher_words[i] = '0;
      end else begin
         drive_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_bytes.push_back(predict_out_byte(current_item));
            op_seen[current_item.op]++;
            gap_count   = 0;
            drive_valid = 1'b0;
         end
         if (!drive_valid && pending_items.size() > 0) begin
            if (gap_count >= pending_items[0].gap &&
                (!pending_items[0].drain || expected_bytes.size() == 0)) begin
               if (pending_items[0].drain) drain_waits++;
               current_item = pending_items.pop_front();
               req_tdata   <= {6'b0, current_item.data_byte,
                               current_item.key_char, current_item.op};
               drive_valid  = 1'b1;
            end else begin
               gap_count++;
            end
         end
         req_tvalid <= drive_valid;
      end
   end

   // ---------------- monitor ----------------

   int unsigned stall_left = 0;
   bit          ready_next;
   logic [7:0]  want_byte;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
      end else begin
         ready_next = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("result 0x%02h with no item outstanding",
                                         rsp_tdata));
            end else begin
               want_byte = expected_bytes.pop_front();
               if (rsp_tdata !== want_byte)
                  report_mismatch($sformatf("result %0d: out_byte 0x%02h, expected 0x%02h",
                                            bytes_checked, rsp_tdata, want_byte));
            end
            bytes_checked++;
            if (bytes_checked % 64 == 0 && $urandom_range(0, 2) == 0)
               steady_sink = ~steady_sink;
            stall_left = steady_sink ? 0 : $urandom_range(0, 17);
            ready_next = (stall_left == 0);
         end else if (!rsp_tready) begin
            if (stall_left > 0) stall_left--;
            if (stall_left == 0) ready_next = 1'b1;
         end
         rsp_tready <= ready_next;
      end
   end

   // ---------------- watchdog ----------------

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ---------------- run control ----------------

   initial begin
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() > 0 || req_tvalid || expected_bytes.size() > 0)
         @(posedge clock);
      // catch any stray result after the last expected one
      repeat (24) @(posedge clock);
      $display("ran %0d start, %0d key, %0d data and %0d unused-opcode items",
               op_seen[OP_START], op_seen[OP_KEY], op_seen[OP_DATA], op_seen[OP_NONE]);
      $display("checked %0d results, %0d drain pauses, %0d mismatches",
               bytes_checked, drain_waits, mismatch_count);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/wmsc_pkg.sv
rtl/core/wmsc_seq.sv
rtl/core/wmsc_dp.sv
rtl/core/word_mixing_stream_cipher.sv
rtl/core/wmsc_checker.sv
bench/word_mixing_stream_cipher_test.sv
